>>> hw/rtl/ftpc_pkg.sv
package ftpc_pkg;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned DivBits = 32;
  localparam int unsigned FrontStages = 7;

  typedef enum logic [2:0] {
    REG_TEMP_ONE  = 3'd0,
    REG_TEMP_TWO  = 3'd1,
    REG_TEMP_THR  = 3'd2,
    REG_PRESS_ONE = 3'd3,
    REG_PRESS_LO  = 3'd4,
    REG_PRESS_HI  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [63:0] plo;
    logic [63:0] phi;
  } cal_t;

  // Front-end result handed to the divide back end
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
  } job_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    asr = 32'($signed(v) >>> s);
  endfunction
endpackage

>>> hw/rtl/ftpc_ram.sv
module ftpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/ftpc_front.sv
// Temperature and divisor/dividend pipeline: seven stages, one item per cycle.
module ftpc_front import ftpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_press,
  input  cal_t        cal,
  output logic        out_valid,
  output job_t        out_job
);
  localparam int unsigned Stages = FrontStages;
  logic [Stages-1:0] vld;

  // stage 1
  logic [31:0] s1_x, s1_d, s1_adcp;
  // stage 2
  logic [31:0] s2_a, s2_dd, s2_adcp;
  // stage 3
  logic [31:0] s3_fine, s3_adcp, s3_bt;
  // stage 4
  logic [31:0] s4_fine, s4_adcp;
  // stage 5
  logic [31:0] s5_fine, s5_temp, s5_qq, s5_ap5, s5_p2a, s5_adcp;
  // stage 6
  logic [31:0] s6_fine, s6_temp, s6_b, s6_ah, s6_adcp;
  // stage 7 results
  logic [31:0] den_w, num_w, s6_den_pre;
  logic [31:0] bt_w, fine_w, b_w, ah_w, a4_w, q4_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  assign bt_w = asr(s2_dd, 12);
  assign fine_w = s3_fine;
  assign a4_w = asr(s4_fine, 1) - 32'd64000;
  assign q4_w = asr(a4_w, 2);
  assign b_w = asr(asr(s5_qq, 11) * sx16(cal.phi[15:0]) + (s5_ap5 << 1), 2)
             + (sx16(cal.plo[47:32]) << 16);
  assign ah_w = asr(asr(sx16(cal.plo[31:16]) * asr(s5_qq, 13), 3) + asr(s5_p2a, 1), 18);
  assign s6_den_pre = 32'd32768 + s6_ah;

  always_ff @(posedge clk) begin
    s1_x    <= ({12'd0, raw_temp} >> 3) - ({16'd0, cal.t1} << 1);
    s1_d    <= ({12'd0, raw_temp} >> 4) - {16'd0, cal.t1};
    s1_adcp <= 32'd1048576 - {12'd0, raw_press};

    s2_a    <= asr(s1_x * sx16(cal.t2), 11);
    s2_dd   <= s1_d * s1_d;
    s2_adcp <= s1_adcp;

    s3_bt   <= asr(bt_w * sx16(cal.t3), 14);
    s3_fine <= s2_a;
    s3_adcp <= s2_adcp;

    s4_fine <= fine_w + s3_bt;
    s4_adcp <= s3_adcp;

    s5_fine <= s4_fine;
    s5_temp <= asr(s4_fine * 32'd5 + 32'd128, 8);
    s5_qq   <= q4_w * q4_w;
    s5_adcp <= s4_adcp;
    s5_ap5  <= a4_w * sx16(cal.plo[63:48]);
    s5_p2a  <= sx16(cal.plo[15:0]) * a4_w;

    s6_fine <= s5_fine;
    s6_temp <= s5_temp;
    s6_b    <= b_w;
    s6_ah   <= ah_w;
    s6_adcp <= s5_adcp;

    out_job.fine <= s6_fine;
    out_job.temp <= s6_temp;
    out_job.den  <= den_w;
    out_job.num  <= num_w;
    out_job.big  <= num_w[31];
  end

  // s3_fine holds the first temperature term; the full fine value lands in s4_fine.
  assign den_w = asr(s6_den_pre * {16'd0, cal.p1}, 15);
  assign num_w = (s6_adcp - asr(s6_b, 12)) * 32'd3125;
  assign out_valid = vld[Stages-1];
endmodule

>>> hw/rtl/ftpc_back.sv
// Unsigned 32-bit divide pipeline (one quotient bit per stage) plus final trim.
module ftpc_back import ftpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  job_t        in_job,
  input  cal_t        cal,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] temp,
  output logic [31:0] fine,
  output logic [31:0] press,
  output logic        dz
);
  localparam int unsigned N = DivBits;

  logic [N:0]    v;
  logic [31:0]   rem  [N+1];
  logic [31:0]   quo  [N+1];
  logic [31:0]   dvd  [N+1];
  logic [31:0]   den  [N+1];
  logic [31:0]   tp   [N+1];
  logic [31:0]   fn   [N+1];
  logic          big  [N+1];
  logic          adv;
  logic [31:0]   p_div, q3, t_a;
  logic          f_v, g_v;
  logic [31:0]   f_p, f_qq, f_p8, f_t, f_f, g_p, g_t, g_f;
  logic          f_z, g_z;

  // A stall freezes the whole chain; the queue ahead absorbs the backlog.
  assign adv = !g_v || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (adv) begin
      v <= {v[N-1:0], in_valid};
      f_v <= v[N];
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= '0;
      quo[0] <= '0;
      dvd[0] <= in_job.big ? in_job.num : (in_job.num << 1);
      den[0] <= in_job.den;
      tp[0]  <= in_job.temp;
      fn[0]  <= in_job.fine;
      big[0] <= in_job.big;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    logic [32:0] trial;
    assign trial = {rem[i], dvd[i][N-1-i]} - {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= trial[32] ? {rem[i][30:0], dvd[i][N-1-i]} : trial[31:0];
        quo[i+1] <= {quo[i][30:0], !trial[32]};
        dvd[i+1] <= dvd[i];
        den[i+1] <= den[i];
        tp[i+1]  <= tp[i];
        fn[i+1]  <= fn[i];
        big[i+1] <= big[i];
      end
    end
  end

  assign p_div = big[N] ? (quo[N] << 1) : quo[N];
  assign q3 = p_div >> 3;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_p  <= p_div;
      f_z  <= (den[N] == '0);
      f_qq <= (q3 * q3) >> 13;
      f_p8 <= asr((p_div >> 2) * sx16(cal.phi[47:32]), 13);
      f_t  <= tp[N];
      f_f  <= fn[N];
      g_p  <= f_z ? '0 : f_p + asr(t_a + f_p8 + sx16(cal.phi[31:16]), 4);
      g_z  <= f_z;
      g_t  <= f_t;
      g_f  <= f_f;
    end
  end

  assign t_a = asr(sx16(cal.phi[63:48]) * f_qq, 12);
  assign out_valid = g_v;
  assign temp = g_t;
  assign fine = g_f;
  assign press = g_p;
  assign dz = g_z;
endmodule

>>> hw/rtl/fixed_temp_press_compensation.sv
// Path from an input transfer to its result on the ports: 7 front stages (the first
// loads at the transfer edge), 1 queue write, 35 back stages. Synchronous active-high
// rst clears control. Throughput: one transfer per cycle on each side unless full or
// empty; the front pipeline never stalls, the back divide pipeline freezes while a result
// waits for pop, and full rises once QDepth + 8 items sit in front + queue.
module fixed_temp_press_compensation import ftpc_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [19:0]        raw_temp,
  input  logic [19:0]        raw_press,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] temp_centideg,
  output logic signed [31:0] fine_temp,
  output logic [31:0]        press_pascal,
  output logic               divisor_zero,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  localparam int unsigned FrontLat = FrontStages;
  localparam int unsigned QSize = QDepth + FrontLat + 1;
  localparam int unsigned CW = $clog2(QSize + 1);

  cal_t cal;
  logic wr;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr) begin
      case (reg_idx_t'(ridx))
        REG_TEMP_ONE:  cal.t1 <= pwdata[15:0];
        REG_TEMP_TWO:  cal.t2 <= pwdata[15:0];
        REG_TEMP_THR:  cal.t3 <= pwdata[15:0];
        REG_PRESS_ONE: cal.p1 <= pwdata[15:0];
        REG_PRESS_LO:  cal.plo <= pwdata;
        REG_PRESS_HI:  cal.phi <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(ridx))
      REG_TEMP_ONE:  prdata = {48'd0, cal.t1};
      REG_TEMP_TWO:  prdata = {48'd0, cal.t2};
      REG_TEMP_THR:  prdata = {48'd0, cal.t3};
      REG_PRESS_ONE: prdata = {48'd0, cal.p1};
      REG_PRESS_LO:  prdata = cal.plo;
      REG_PRESS_HI:  prdata = cal.phi;
      default:       prdata = '0;
    endcase
  end

  // front pipeline
  logic f_valid;
  job_t f_job;
  logic acc;
  assign acc = push && !full;

  ftpc_front u_front (
    .clk, .rst, .in_valid(acc), .raw_temp, .raw_press, .cal,
    .out_valid(f_valid), .out_job(f_job)
  );

  // queue between front and back: credit counts items in front + queue
  localparam int unsigned AW = $clog2(QSize);
  logic [AW-1:0] wp, rp, rp_next;
  logic [CW-1:0] credit, qcnt;
  logic b_ready, q_pop, q_valid;
  job_t q_job;
  logic [$bits(job_t)-1:0] q_raw;
  logic byp;
  job_t byp_job;

  assign full = (credit == CW'(QSize));
  assign q_valid = (qcnt != '0);
  assign q_pop = q_valid && b_ready;
  assign rp_next = rp + AW'(q_pop);

  // Read address runs one step ahead; the registered read shows the head unless bypassed.
  ftpc_ram #(.Width($bits(job_t)), .Depth(2**AW)) u_q (
    .clk, .we(f_valid), .waddr(wp), .wdata(f_job), .raddr(rp_next), .rdata(q_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; credit <= '0; qcnt <= '0; byp <= 1'b0;
    end else begin
      if (f_valid) wp <= wp + 1'b1;
      rp <= rp_next;
      credit <= credit + CW'(acc) - CW'(q_pop);
      qcnt <= qcnt + CW'(f_valid) - CW'(q_pop);
      // item written into the slot being read this edge: RAM output is stale
      byp <= f_valid && (wp == rp_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_job <= f_job;
  end

  assign q_job = byp ? byp_job : job_t'(q_raw);

  logic b_valid;
  logic [31:0] b_t, b_f, b_p;
  logic b_z;

  ftpc_back u_back (
    .clk, .rst, .in_valid(q_pop), .in_ready(b_ready), .in_job(q_job), .cal,
    .out_valid(b_valid), .out_ready(pop), .temp(b_t), .fine(b_f), .press(b_p), .dz(b_z)
  );

  assign empty = !b_valid;
  assign temp_centideg = $signed(b_t);
  assign fine_temp = $signed(b_f);
  assign press_pascal = b_p;
  assign divisor_zero = b_z;
endmodule

>>> hw/rtl/ftpc_check.sv
module ftpc_check (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input logic divisor_zero,
  input logic [31:0] press_pascal
);
  a_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && divisor_zero |-> press_pascal == '0) else $error("zero divisor press");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("result dropped");
  a_rst: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("not idle after reset");
endmodule

bind fixed_temp_press_compensation ftpc_check u_check (
  .clk, .rst, .full, .empty, .pop, .divisor_zero, .press_pascal
);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ftpc_pkg::*;

  // One raw sample pair on the way in
  typedef struct {
    logic [19:0] t_raw;
    logic [19:0] p_raw;
  } sample_t;

  // One compensated reading on the way out
  typedef struct {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] press;
    logic        dz;
  } reading_t;

  localparam int Latency   = 43;
  localparam int StallLimit = 20000;

  logic        clk, rst;
  logic        push, full, empty, pop;
  logic [19:0] raw_temp, raw_press;
  logic signed [31:0] temp_centideg, fine_temp;
  logic [31:0] press_pascal;
  logic        divisor_zero;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  fixed_temp_press_compensation uut (
    .clk, .rst, .push, .full, .raw_temp, .raw_press, .empty, .pop,
    .temp_centideg, .fine_temp, .press_pascal, .divisor_zero,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow copy of the calibration registers
  logic [15:0] cal_t1, cal_t2, cal_t3, cal_p1;
  logic [63:0] cal_plo, cal_phi;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       errors = 0;
  int       n_readings = 0;
  int       n_zero_div = 0;
  bit       quiet = 0;      // no idling in the final stretch
  int       push_gap = 0, pop_gap = 0;
  int       stall_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sar(logic [31:0] v, int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // Integer compensation, 32-bit wrapping throughout
  function automatic reading_t compensate(sample_t s);
    reading_t r;
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, p;
    adc_t = {12'd0, s.t_raw};
    adc_p = {12'd0, s.p_raw};
    t1 = {16'd0, cal_t1};
    t2 = ext16(cal_t2);
    t3 = ext16(cal_t3);
    p1 = {16'd0, cal_p1};
    p2 = ext16(cal_plo[15:0]);
    p3 = ext16(cal_plo[31:16]);
    p4 = ext16(cal_plo[47:32]);
    p5 = ext16(cal_plo[63:48]);
    p6 = ext16(cal_phi[15:0]);
    p7 = ext16(cal_phi[31:16]);
    p8 = ext16(cal_phi[47:32]);
    p9 = ext16(cal_phi[63:48]);

    a = sar(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = sar(sar(d * d, 12) * t3, 14);
    fine = a + b;
    r.temp = sar(fine * 32'd5 + 32'd128, 8);
    r.fine = fine;

    a = sar(fine, 1) - 32'd64000;
    q = sar(a, 2);
    b = sar(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sar(b, 2) + (p4 << 16);
    a = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * a, 1), 18);
    a = sar((32'd32768 + a) * p1, 15);

    if (a == 0) begin
      r.press = 0;
      r.dz = 1;
    end else begin
      r.dz = 0;
      p = ((32'd1048576 - adc_p) - sar(b, 12)) * 32'd3125;
      // large dividend: divide first, then double
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      a = sar(p9 * ((q * q) >> 13), 12);
      b = sar((p >> 2) * p8, 13);
      r.press = p + sar(a + b + p7, 4);
    end
    return r;
  endfunction

  // Driver: the head of the pending queue is on the bus until it transfers
  always @(posedge clk) begin
    if (rst) begin
      push      <= 0;
      raw_temp  <= 0;
      raw_press <= 0;
    end else begin
      if (push && !full) begin
        expected_readings.push_back(compensate('{raw_temp, raw_press}));
        void'(pending_samples.pop_front());
      end
      if (push && full) begin
        // hold the current item until it transfers
      end else if (pending_samples.size() > 0 && push_gap == 0) begin
        push      <= 1;
        raw_temp  <= pending_samples[0].t_raw;
        raw_press <= pending_samples[0].p_raw;
        if (!quiet && $urandom_range(0, 9) == 0) push_gap = $urandom_range(1, 3);
      end else begin
        push <= 0;
        if (push_gap > 0) push_gap--;
      end
    end
  end

  // Monitor: checks each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        reading_t e;
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: temp %0d", temp_centideg);
          errors++;
        end else begin
          e = expected_readings.pop_front();
          n_readings++;
          if (e.dz) n_zero_div++;
          if (temp_centideg !== e.temp) begin
            $error("temp_centideg exp %0d got %0d", $signed(e.temp), temp_centideg);
            errors++;
          end
          if (fine_temp !== e.fine) begin
            $error("fine_temp exp %0d got %0d", $signed(e.fine), fine_temp);
            errors++;
          end
          if (press_pascal !== e.press) begin
            $error("press_pascal exp %0d got %0d", e.press, press_pascal);
            errors++;
          end
          if (divisor_zero !== e.dz) begin
            $error("divisor_zero exp %0b got %0b", e.dz, divisor_zero);
            errors++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop <= 0;
        pop_gap--;
      end else begin
        pop <= 1;
        if (!quiet && $urandom_range(0, 7) == 0) pop_gap = $urandom_range(1, 3);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 6'(8 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (idx)
      REG_TEMP_ONE:  cal_t1  = val[15:0];
      REG_TEMP_TWO:  cal_t2  = val[15:0];
      REG_TEMP_THR:  cal_t3  = val[15:0];
      REG_PRESS_ONE: cal_p1  = val[15:0];
      REG_PRESS_LO:  cal_plo = val;
      REG_PRESS_HI:  cal_phi = val;
      default: ;
    endcase
  endtask

  // Wait until the pipeline has fully drained
  task automatic drain();
    wait (pending_samples.size() == 0 && !push && expected_readings.size() == 0);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic load_cal(logic [15:0] t1, t2, t3, p1, logic [63:0] lo, hi);
    reg_write(REG_TEMP_ONE, {48'd0, t1});
    reg_write(REG_TEMP_TWO, {48'd0, t2});
    reg_write(REG_TEMP_THR, {48'd0, t3});
    reg_write(REG_PRESS_ONE, {48'd0, p1});
    reg_write(REG_PRESS_LO, lo);
    reg_write(REG_PRESS_HI, hi);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_samples.push_back('{20'($urandom), 20'($urandom)});
  endtask

  // Realistic calibration with random jitter on eight of the twelve words
  task automatic load_typical_cal();
    load_cal(16'(27504 + $urandom_range(0, 2000)), 16'(26435 - $urandom_range(0, 2000)),
             16'(-1000 + $urandom_range(0, 300)), 16'(36477 + $urandom_range(0, 3000)),
             {16'(2855), 16'(-7000 + $urandom_range(0, 400)),
              16'(24000 + $urandom_range(0, 1500)), 16'(-10685 + $urandom_range(0, 500))},
             {16'(6000), 16'(-7000 - $urandom_range(0, 600)),
              16'(15500), 16'(-7)});
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cal_t1 = 0; cal_t2 = 0; cal_t3 = 0; cal_p1 = 0; cal_plo = 0; cal_phi = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Reset calibration: p1 = 0, so every divisor is zero
    pending_samples.push_back('{20'h00000, 20'h00000});
    pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
    drain();

    // Directed: typical calibration, field extremes
    load_cal(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
             {16'd2855, 16'd140, 16'hD9FF, 16'hD5D0},   // packed words five..two
             {16'd6000, 16'hEED8, 16'h3C7A, 16'hFFF9});  // nine..six
    pending_samples.push_back('{20'h00000, 20'h00000});
    pending_samples.push_back('{20'hFFFFF, 20'h00000});
    pending_samples.push_back('{20'h00000, 20'hFFFFF});
    pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
    pending_samples.push_back('{20'd519888, 20'd415148});
    pending_samples.push_back('{20'h55555, 20'hAAAAA});
    pending_samples.push_back('{20'hAAAAA, 20'h55555});
    drain();

    // Extreme calibration: all-ones, most-negative and most-positive words, large dividends
    load_cal(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
             64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_7FFF_8000);
    pending_samples.push_back('{20'h00000, 20'hFFFFF});
    pending_samples.push_back('{20'hFFFFF, 20'h00000});
    pending_samples.push_back('{20'h80000, 20'h80000});
    queue_random(8);
    drain();

    // Random parts, calibration changed between phases
    for (int ph = 0; ph < 7; ph++) begin
      if (ph % 3 == 2)
        load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 {$urandom, $urandom}, {$urandom, $urandom});
      else load_typical_cal();
      if (ph == 6) quiet = 1;
      queue_random(248);
      drain();   // sender holds until every reading is back
    end

    $display("covered %0d readings over 10 calibration sets, %0d with zero divisor",
             n_readings, n_zero_div);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ftpc_pkg.sv
hw/rtl/ftpc_ram.sv
hw/rtl/ftpc_front.sv
hw/rtl/ftpc_back.sv
hw/rtl/fixed_temp_press_compensation.sv
hw/rtl/ftpc_check.sv
bench/tb_top.sv
